[rtl/keyboard_poll_bridge_defines.svh]
// Assertion macros used by the checker file.
`ifndef KEYBOARD_POLL_BRIDGE_DEFINES_SVH
`define KEYBOARD_POLL_BRIDGE_DEFINES_SVH

// Property checked on every rising clock edge outside reset.
`define KPB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define KPB_NEVER(label, cond, msg) \
  `KPB_ASSERT(label, !(cond), msg)

`endif

[rtl/kpb_pkg.sv]
package kpb_pkg;

  localparam int unsigned TIME_W     = 48;
  localparam int unsigned INTERVAL_W = 24;
  localparam int unsigned ADDR_W     = 8;
  localparam int unsigned KEYS_W     = 48;
  localparam int unsigned CFG_IDX_W  = 3;

  localparam logic [7:0]  CMD_INFO_ANSWER = 8'h05;
  localparam logic [7:0]  CMD_DATA_ANSWER = 8'h08;
  localparam logic [31:0] FN_KEYBOARD     = 32'h0000_0040;
  localparam int unsigned FN_KEYBOARD_BIT = 6;

  localparam logic [1:0] WORDS_FULL_COND = 2'd3;

  localparam logic [INTERVAL_W-1:0] POLL_INTERVAL_RST   = 24'd8000;
  localparam logic [INTERVAL_W-1:0] PROBE_INTERVAL_RST  = 24'd250000;
  localparam logic [INTERVAL_W-1:0] RELEASE_TIMEOUT_RST = 24'd100000;
  localparam logic [ADDR_W-1:0]     DEVICE_ADDRESS_RST  = 8'h20;
  localparam logic [ADDR_W-1:0]     HOST_ADDRESS_RST    = 8'h00;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POLL_INTERVAL   = 3'd0,
    REG_PROBE_INTERVAL  = 3'd1,
    REG_RELEASE_TIMEOUT = 3'd2,
    REG_DEVICE_ADDRESS  = 3'd3,
    REG_HOST_ADDRESS    = 3'd4
  } reg_index_t;

  localparam logic [1:0] REQ_NONE       = 2'd0;
  localparam logic [1:0] REQ_INFO_PROBE = 2'd1;
  localparam logic [1:0] REQ_GET_COND   = 2'd2;

  typedef struct packed {
    logic [TIME_W-1:0] now_us;
    logic              bus_busy;
    logic              usb_ready;
    logic              usb_mounted;
    logic              resp_valid;
    logic [7:0]        resp_sender;
    logic [7:0]        resp_recipient;
    logic [7:0]        resp_command;
    logic [1:0]        payload_words;
    logic [31:0]       function_word;
    logic [31:0]       cond_word_one;
    logic [31:0]       cond_word_two;
  } item_t;

  typedef struct packed {
    logic [1:0]        request_kind;
    logic              report_send;
    logic [7:0]        report_modifiers;
    logic [KEYS_W-1:0] report_keys;
    logic              keyboard_present;
    logic              led_on;
  } result_t;

  typedef struct packed {
    logic [INTERVAL_W-1:0] poll_interval;
    logic [INTERVAL_W-1:0] probe_interval;
    logic [INTERVAL_W-1:0] release_timeout;
    logic [ADDR_W-1:0]     device_address;
    logic [ADDR_W-1:0]     host_address;
  } cfg_t;

endpackage

[rtl/kpb_cfg_regs.sv]
module kpb_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [kpb_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [kpb_pkg::INTERVAL_W-1:0] wr_data,
  output kpb_pkg::cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.poll_interval   <= kpb_pkg::POLL_INTERVAL_RST;
      cfg.probe_interval  <= kpb_pkg::PROBE_INTERVAL_RST;
      cfg.release_timeout <= kpb_pkg::RELEASE_TIMEOUT_RST;
      cfg.device_address  <= kpb_pkg::DEVICE_ADDRESS_RST;
      cfg.host_address    <= kpb_pkg::HOST_ADDRESS_RST;
    end else if (wr_en) begin
      unique case (kpb_pkg::reg_index_t'(wr_index))
        kpb_pkg::REG_POLL_INTERVAL:   cfg.poll_interval   <= wr_data;
        kpb_pkg::REG_PROBE_INTERVAL:  cfg.probe_interval  <= wr_data;
        kpb_pkg::REG_RELEASE_TIMEOUT: cfg.release_timeout <= wr_data;
        kpb_pkg::REG_DEVICE_ADDRESS:  cfg.device_address  <= wr_data[kpb_pkg::ADDR_W-1:0];
        kpb_pkg::REG_HOST_ADDRESS:    cfg.host_address    <= wr_data[kpb_pkg::ADDR_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

endmodule

[rtl/kpb_step.sv]
module kpb_step (
  input  logic             clk,
  input  logic             rst,
  input  logic             step_en,
  input  kpb_pkg::item_t   item,
  input  kpb_pkg::cfg_t    cfg,
  output kpb_pkg::result_t result_next
);

  localparam int unsigned TW = kpb_pkg::TIME_W;
  localparam int unsigned RW = kpb_pkg::KEYS_W + 8;

  // loop state
  logic [RW-1:0] current_report;
  logic          report_waiting;
  logic [TW-1:0] next_request_time;
  logic [TW-1:0] last_answer_time;
  logic          present_flag;
  logic          indicator_flag;

  logic [RW-1:0] current_report_next;
  logic          report_waiting_next;
  logic [TW-1:0] next_request_time_next;
  logic [TW-1:0] last_answer_time_next;
  logic          present_flag_next;
  logic          indicator_flag_next;

  logic          addr_ok, info_ok, data_ok, answer, timeout, issue, send;
  logic [RW-1:0] new_report;
  logic [TW-1:0] elapsed, poll_time, nrt_mid, issue_time;
  logic [kpb_pkg::INTERVAL_W-1:0] interval;

  always_comb begin
    addr_ok = item.resp_valid
              && (item.resp_sender == cfg.device_address)
              && (item.resp_recipient == cfg.host_address);
    info_ok = addr_ok && (item.resp_command == kpb_pkg::CMD_INFO_ANSWER)
              && (item.payload_words != 2'd0)
              && item.function_word[kpb_pkg::FN_KEYBOARD_BIT];
    data_ok = addr_ok && (item.resp_command == kpb_pkg::CMD_DATA_ANSWER)
              && (item.payload_words == kpb_pkg::WORDS_FULL_COND)
              && (item.function_word == kpb_pkg::FN_KEYBOARD);
    answer  = info_ok || data_ok;

    // modifiers, key0, key1, key2..key5; leds byte dropped
    new_report = {item.cond_word_one[31:24], item.cond_word_one[15:8],
                  item.cond_word_one[7:0], item.cond_word_two};

    // an answer this step blocks the timeout outright, so it can't time out
    elapsed = item.now_us - last_answer_time;
    timeout = !answer && (last_answer_time != '0)
              && (elapsed > {{(TW-kpb_pkg::INTERVAL_W){1'b0}}, cfg.release_timeout});

    poll_time = item.now_us + {{(TW-kpb_pkg::INTERVAL_W){1'b0}}, cfg.poll_interval};

    if (data_ok) begin
      current_report_next = new_report;
    end else if (timeout) begin
      current_report_next = '0;
    end else begin
      current_report_next = current_report;
    end

    present_flag_next   = answer  ? 1'b1 : (timeout ? 1'b0 : present_flag);
    indicator_flag_next = data_ok ? 1'b1 : (timeout ? 1'b0 : indicator_flag);
    if (answer) begin
      last_answer_time_next = item.now_us;
    end else if (timeout) begin
      last_answer_time_next = '0;
    end else begin
      last_answer_time_next = last_answer_time;
    end

    if (info_ok) begin
      nrt_mid = poll_time;
    end else if (timeout) begin
      nrt_mid = item.now_us;
    end else begin
      nrt_mid = next_request_time;
    end

    // request scheduling
    issue      = !item.bus_busy && (item.now_us >= nrt_mid);
    interval   = present_flag_next ? cfg.poll_interval : cfg.probe_interval;
    issue_time = item.now_us + {{(TW-kpb_pkg::INTERVAL_W){1'b0}}, interval};
    next_request_time_next = issue ? issue_time : nrt_mid;

    // report emission; a changed report or a mount event arms it
    report_waiting_next = report_waiting || item.usb_mounted
                          || (current_report_next != current_report);
    send = report_waiting_next && item.usb_ready;
    if (send) begin
      report_waiting_next = 1'b0;
    end

    result_next.request_kind     = issue ? (present_flag_next ? kpb_pkg::REQ_GET_COND
                                                              : kpb_pkg::REQ_INFO_PROBE)
                                         : kpb_pkg::REQ_NONE;
    result_next.report_send      = send;
    result_next.report_modifiers = send ? current_report_next[RW-1 -: 8] : 8'd0;
    result_next.report_keys      = send ? current_report_next[kpb_pkg::KEYS_W-1:0] : '0;
    result_next.keyboard_present = present_flag_next;
    result_next.led_on           = indicator_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_report    <= '0;
      report_waiting    <= 1'b1;
      next_request_time <= '0;
      last_answer_time  <= '0;
      present_flag      <= 1'b0;
      indicator_flag    <= 1'b0;
    end else if (step_en) begin
      current_report    <= current_report_next;
      report_waiting    <= report_waiting_next;
      next_request_time <= next_request_time_next;
      last_answer_time  <= last_answer_time_next;
      present_flag      <= present_flag_next;
      indicator_flag    <= indicator_flag_next;
    end
  end

endmodule

[rtl/keyboard_poll_bridge.sv]
// Path: each item is held in the input register, then its result is captured in the
//   result register once that register is empty or being drained; a stalled result
//   holds the item back.
// Throughput: one item per cycle while the result channel is not stalled; the whole loop
//   iteration is one pass of compare-and-update logic in kpb_step between the two registers.
// Reset (rst, synchronous, active high): both channels empty, registers at their
//   defaults, report pending, keyboard absent, no answer time recorded.
module keyboard_poll_bridge (
  input  logic                           clk,
  input  logic                           rst,
  // item channel
  input  logic                           item_valid,
  output logic                           item_stall,
  input  kpb_pkg::item_t                 item,
  // result channel
  output logic                           result_valid,
  input  logic                           result_stall,
  output kpb_pkg::result_t               result,
  // register write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [kpb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kpb_pkg::INTERVAL_W-1:0] cfg_data
);

  kpb_pkg::cfg_t    cfg;
  kpb_pkg::item_t   item_q;
  kpb_pkg::result_t result_next;
  logic             item_q_valid;
  logic             advance;

  // Registers are always writable; the user must write only while idle, as the block does not enforce it.
  assign cfg_ready = 1'b1;

  kpb_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // The held item moves on whenever the result register is empty or being drained,
  // so a finished result waiting on the far side never blocks the next transfer
  // unless it is itself stalled.
  assign advance    = item_q_valid && (!result_valid || !result_stall);
  assign item_stall = item_q_valid && !advance;

  // Input register: refills whenever it is empty or its contents advance.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
    end else if (!item_stall) begin
      item_q_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall && item_valid) begin
      item_q <= item;
    end
  end

  // One service-loop iteration; state commits only on advance.
  kpb_step u_step (
    .clk         (clk),
    .rst         (rst),
    .step_en     (advance),
    .item        (item_q),
    .cfg         (cfg),
    .result_next (result_next)
  );

  // Result register: holds while stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

endmodule

[rtl/kpb_checker.sv]
`include "keyboard_poll_bridge_defines.svh"

module kpb_checker (
  input logic             clk,
  input logic             rst,
  input logic             result_valid,
  input logic             result_stall,
  input kpb_pkg::result_t result
);

  `KPB_ASSERT(a_result_hold, (result_valid && result_stall) |=> (result_valid && $stable(result)), "stalled result changed")
  `KPB_NEVER(a_kind_code, result_valid && (result.request_kind != kpb_pkg::REQ_NONE) && (result.request_kind != kpb_pkg::REQ_INFO_PROBE) && (result.request_kind != kpb_pkg::REQ_GET_COND), "bad request kind")
  `KPB_NEVER(a_idle_report, result_valid && !result.report_send && ((result.report_modifiers != 8'd0) || (result.report_keys != '0)), "report fields set without send")
  `KPB_NEVER(a_led_present, result_valid && result.led_on && !result.keyboard_present, "activity led without keyboard")

endmodule

bind keyboard_poll_bridge kpb_checker u_kpb_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

[test/keyboard_poll_bridge_test.sv]
`timescale 1ns / 100ps

module keyboard_poll_bridge_test;

  // Cycles with no transfer on any channel before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 2000;
  // Settle time after the last result is back, before touching registers.
  localparam int SETTLE_CYCLES = 6;
  // Index past the register list; the block must drop the write.
  localparam logic [kpb_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic                           clk = 1'b0;
  logic                           rst;
  logic                           item_valid;
  logic                           item_stall;
  kpb_pkg::item_t                 item;
  logic                           result_valid;
  logic                           result_stall = 1'b0;
  kpb_pkg::result_t               result;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [kpb_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [kpb_pkg::INTERVAL_W-1:0] cfg_data;

  keyboard_poll_bridge u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow copy of the bridge: registers and loop state.
  // ---------------------------------------------------------------------------
  logic [kpb_pkg::INTERVAL_W-1:0] poll_us;
  logic [kpb_pkg::INTERVAL_W-1:0] probe_us;
  logic [kpb_pkg::INTERVAL_W-1:0] release_us;
  logic [kpb_pkg::ADDR_W-1:0]     kbd_addr;
  logic [kpb_pkg::ADDR_W-1:0]     host_addr;

  logic [55:0]                    held_report;     // modifiers on top, then key0..key5
  logic                           report_due;
  logic [kpb_pkg::TIME_W-1:0]     next_request_us;
  logic [kpb_pkg::TIME_W-1:0]     last_answer_us;  // zero reads as "no answer yet"
  logic                           kbd_present;
  logic                           activity_led;

  // Per-iteration outcomes still owed by the block, oldest first.
  kpb_pkg::result_t               loop_outcomes[$];

  int                             errors = 0;
  int                             stuck_cycles = 0;
  int                             idle_odds = 0;   // 1-in-N chance of a gap/stall burst
  int unsigned                    stride_max = 1;  // largest random time step in us
  logic [kpb_pkg::TIME_W-1:0]     clock_us = '0;   // time base for random traffic
  logic [31:0]                    last_w1 = '0;
  logic [31:0]                    last_w2 = '0;

  task automatic reset_model();
    poll_us         = kpb_pkg::POLL_INTERVAL_RST;
    probe_us        = kpb_pkg::PROBE_INTERVAL_RST;
    release_us      = kpb_pkg::RELEASE_TIMEOUT_RST;
    kbd_addr        = kpb_pkg::DEVICE_ADDRESS_RST;
    host_addr       = kpb_pkg::HOST_ADDRESS_RST;
    held_report     = '0;
    report_due      = 1'b1;
    next_request_us = '0;
    last_answer_us  = '0;
    kbd_present     = 1'b0;
    activity_led    = 1'b0;
  endtask

  function automatic void apply_register(logic [kpb_pkg::CFG_IDX_W-1:0] idx,
                                         logic [kpb_pkg::INTERVAL_W-1:0] data);
    case (idx)
      kpb_pkg::REG_POLL_INTERVAL:   poll_us = data;
      kpb_pkg::REG_PROBE_INTERVAL:  probe_us = data;
      kpb_pkg::REG_RELEASE_TIMEOUT: release_us = data;
      kpb_pkg::REG_DEVICE_ADDRESS:  kbd_addr = data[kpb_pkg::ADDR_W-1:0];
      kpb_pkg::REG_HOST_ADDRESS:    host_addr = data[kpb_pkg::ADDR_W-1:0];
      default: ;
    endcase
  endfunction

  // Only a changed report gets queued for USB.
  function automatic void store_report(logic [55:0] rep);
    if (rep != held_report) begin
      held_report = rep;
      report_due  = 1'b1;
    end
  endfunction

  // One service-loop iteration: answer decode, silence release, request pick,
  // then USB emission.
  function automatic kpb_pkg::result_t service_loop(kpb_pkg::item_t it);
    kpb_pkg::result_t           r;
    logic [kpb_pkg::TIME_W-1:0] silence;
    r = '0;
    if (it.usb_mounted) report_due = 1'b1;

    if (it.resp_valid && it.resp_sender == kbd_addr && it.resp_recipient == host_addr) begin
      if (it.resp_command == kpb_pkg::CMD_INFO_ANSWER && it.payload_words >= 2'd1 &&
          it.function_word[kpb_pkg::FN_KEYBOARD_BIT]) begin
        kbd_present     = 1'b1;
        last_answer_us  = it.now_us;
        next_request_us = it.now_us + poll_us;
      end else if (it.resp_command == kpb_pkg::CMD_DATA_ANSWER &&
                   it.payload_words >= kpb_pkg::WORDS_FULL_COND &&
                   it.function_word == kpb_pkg::FN_KEYBOARD) begin
        // LED byte (cond_word_one[23:16]) is dropped
        store_report({it.cond_word_one[31:24], it.cond_word_one[15:8],
                      it.cond_word_one[7:0], it.cond_word_two});
        kbd_present    = 1'b1;
        last_answer_us = it.now_us;
        activity_led   = 1'b1;
      end
    end

    silence = it.now_us - last_answer_us;
    if (last_answer_us != '0 && silence > release_us) begin
      store_report('0);
      last_answer_us  = '0;
      kbd_present     = 1'b0;
      next_request_us = it.now_us;
      activity_led    = 1'b0;
    end

    if (!it.bus_busy && it.now_us >= next_request_us) begin
      if (kbd_present) begin
        r.request_kind  = kpb_pkg::REQ_GET_COND;
        next_request_us = it.now_us + poll_us;
      end else begin
        r.request_kind  = kpb_pkg::REQ_INFO_PROBE;
        next_request_us = it.now_us + probe_us;
      end
    end

    if (report_due && it.usb_ready) begin
      r.report_send      = 1'b1;
      r.report_modifiers = held_report[55:48];
      r.report_keys      = held_report[47:0];
      report_due         = 1'b0;
    end

    r.keyboard_present = kbd_present;
    r.led_on           = activity_led;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Channel drivers. Inputs move on the falling edge, handshakes are sampled
  // on the rising edge.
  // ---------------------------------------------------------------------------

  // Send one loop iteration; valid stays high into the next call unless a gap
  // is taken, so it is never dropped and raised in the same step.
  task automatic send_item(kpb_pkg::item_t it);
    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    item       <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    loop_outcomes.push_back(service_loop(it));
    @(negedge clk);
  endtask

  // Hold off the sender until every outstanding result is back.
  task automatic drain();
    item_valid <= 1'b0;
    while (loop_outcomes.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Register write; only called with the block idle.
  task automatic write_reg(logic [kpb_pkg::CFG_IDX_W-1:0] idx,
                           logic [kpb_pkg::INTERVAL_W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_register(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Result side backpressure in random bursts.
  always begin
    @(negedge clk);
    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      result_stall <= 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      result_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    kpb_pkg::result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (loop_outcomes.size() == 0) begin
        errors++;
        $display("%0t: result with nothing outstanding, expected none, actual %h",
                 $time, result);
      end else begin
        want = loop_outcomes.pop_front();
        check_field("request_kind", want.request_kind, result.request_kind);
        check_field("report_send", want.report_send, result.report_send);
        check_field("report_modifiers", want.report_modifiers, result.report_modifiers);
        check_field("report_keys", want.report_keys, result.report_keys);
        check_field("keyboard_present", want.keyboard_present, result.keyboard_present);
        check_field("led_on", want.led_on, result.led_on);
      end
    end
  end

  // Hang detector: any transfer on any channel restarts the count.
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("keyboard_poll_bridge_test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Item builders
  // ---------------------------------------------------------------------------
  function automatic kpb_pkg::item_t idle_item(logic [kpb_pkg::TIME_W-1:0] t, logic ready);
    kpb_pkg::item_t it;
    it           = '0;
    it.now_us    = t;
    it.usb_ready = ready;
    return it;
  endfunction

  // Correctly addressed response frame.
  function automatic kpb_pkg::item_t answer_item(logic [kpb_pkg::TIME_W-1:0] t,
                                                 logic [7:0] cmd,
                                                 logic [1:0] words, logic [31:0] fn,
                                                 logic [31:0] w1, logic [31:0] w2);
    kpb_pkg::item_t it;
    it                = idle_item(t, 1'b1);
    it.resp_valid     = 1'b1;
    it.resp_sender    = kbd_addr;
    it.resp_recipient = host_addr;
    it.resp_command   = cmd;
    it.payload_words  = words;
    it.function_word  = fn;
    it.cond_word_one  = w1;
    it.cond_word_two  = w2;
    return it;
  endfunction

  // Mostly well-formed answers to our own address pair, with a share of
  // misaddressed, wrong-command, short and bad-function frames mixed in.
  function automatic kpb_pkg::item_t random_item();
    kpb_pkg::item_t it;
    int unsigned    pick;
    pick = $urandom_range(0, 29);
    if (pick == 0)
      clock_us = clock_us + release_us + $urandom_range(1, stride_max);  // force silence
    else
      clock_us = clock_us + $urandom_range(0, stride_max);
    it.now_us      = clock_us;
    it.bus_busy    = ($urandom_range(0, 3) == 0);
    it.usb_ready   = ($urandom_range(0, 2) != 0);
    it.usb_mounted = ($urandom_range(0, 19) == 0);
    it.resp_valid  = ($urandom_range(0, 2) != 0);

    pick = $urandom_range(0, 9);
    it.resp_sender    = (pick == 0) ? 8'($urandom) : kbd_addr;
    it.resp_recipient = (pick == 1) ? 8'($urandom) : host_addr;

    pick = $urandom_range(0, 9);
    it.resp_command = (pick < 4) ? kpb_pkg::CMD_INFO_ANSWER :
                      (pick < 9) ? kpb_pkg::CMD_DATA_ANSWER : 8'($urandom);
    it.payload_words = ($urandom_range(0, 4) == 0) ? 2'($urandom)
                                                   : kpb_pkg::WORDS_FULL_COND;

    pick = $urandom_range(0, 9);
    it.function_word = (pick < 7) ? kpb_pkg::FN_KEYBOARD :
                       (pick < 9) ? ($urandom | kpb_pkg::FN_KEYBOARD) : $urandom;

    // repeat the last key state now and then so unchanged reports are seen
    if ($urandom_range(0, 2) == 0) begin
      it.cond_word_one = last_w1;
      it.cond_word_two = last_w2;
    end else begin
      it.cond_word_one = $urandom;
      it.cond_word_two = $urandom;
    end
    last_w1 = it.cond_word_one;
    last_w2 = it.cond_word_two;
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset config: presence, report updates, address/command filtering, release.
  task automatic test_answers();
    kpb_pkg::item_t it;
    idle_odds = 5;
    send_item(idle_item(48'd0, 1'b0));                 // probe at t=0, report held back
    // answer stamped at time zero does not arm the release timer
    send_item(answer_item(48'd0, kpb_pkg::CMD_INFO_ANSWER, 2'd1, kpb_pkg::FN_KEYBOARD,
                          '0, '0));
    it = idle_item(48'd10, 1'b1);
    it.usb_mounted = 1'b1;                             // mount forces a resend
    send_item(it);
    send_item(answer_item(48'd8000, kpb_pkg::CMD_DATA_ANSWER, kpb_pkg::WORDS_FULL_COND,
                          kpb_pkg::FN_KEYBOARD, 32'hFFAA_1234, 32'hDEAD_BEEF));
    send_item(answer_item(48'd8001, kpb_pkg::CMD_DATA_ANSWER, kpb_pkg::WORDS_FULL_COND,
                          kpb_pkg::FN_KEYBOARD, 32'hFF55_1234,
                          32'hDEAD_BEEF));             // only LEDs differ: no report
    send_item(answer_item(48'd8002, kpb_pkg::CMD_DATA_ANSWER, 2'd2, kpb_pkg::FN_KEYBOARD,
                          32'h0100_0004, '0));         // short payload
    send_item(answer_item(48'd8003, kpb_pkg::CMD_DATA_ANSWER, kpb_pkg::WORDS_FULL_COND,
                          kpb_pkg::FN_KEYBOARD | 32'd1,
                          32'h0100_0004, '0));         // function must match exactly
    it = answer_item(48'd8004, kpb_pkg::CMD_DATA_ANSWER, kpb_pkg::WORDS_FULL_COND,
                     kpb_pkg::FN_KEYBOARD, 32'h0200_0005, '0);
    it.resp_sender = ~kbd_addr;
    send_item(it);
    it.now_us         = 48'd8005;
    it.resp_sender    = kbd_addr;
    it.resp_recipient = ~host_addr;
    send_item(it);
    send_item(answer_item(48'd8006, kpb_pkg::CMD_INFO_ANSWER, 2'd0, kpb_pkg::FN_KEYBOARD,
                          '0, '0));
    it = idle_item(48'd16000, 1'b1);
    it.bus_busy = 1'b1;                                // poll due, bus still busy
    send_item(it);
    send_item(idle_item(48'd16001, 1'b1));
    send_item(idle_item(48'd108001, 1'b1));            // silence exactly at the limit
    send_item(idle_item(48'd108002, 1'b1));            // one past: keys released
    clock_us = 48'd108002;
  endtask

  // Time counter rolls over; an all-ones frame is ignored on the way.
  task automatic test_time_wrap();
    send_item(answer_item(48'hFFFF_FFFF_FFF0, kpb_pkg::CMD_DATA_ANSWER,
                          kpb_pkg::WORDS_FULL_COND, kpb_pkg::FN_KEYBOARD,
                          32'h8000_0029, 32'h0));
    send_item('1);
    send_item(idle_item(48'd5, 1'b1));                 // short silence across the wrap
    send_item(idle_item(48'd100105, 1'b1));            // long silence across the wrap
    clock_us = 48'd100105;
  endtask

  // Register extremes, including a write to an unused index.
  task automatic test_register_extremes();
    drain();
    write_reg(kpb_pkg::REG_POLL_INTERVAL, 24'd1);
    write_reg(kpb_pkg::REG_PROBE_INTERVAL, 24'hFF_FFFF);
    write_reg(kpb_pkg::REG_RELEASE_TIMEOUT, 24'hFF_FFFF);
    write_reg(kpb_pkg::REG_DEVICE_ADDRESS, 24'h00_00FF);
    write_reg(kpb_pkg::REG_HOST_ADDRESS, 24'hFF_FFFF);  // upper bits dropped
    write_reg(REG_UNUSED, 24'hFF_FFFF);
    clock_us = clock_us + 1;
    send_item(answer_item(clock_us, kpb_pkg::CMD_INFO_ANSWER, kpb_pkg::WORDS_FULL_COND,
                          32'hFFFF_FFFF, '1, '1));
    send_item(idle_item(clock_us + 1, 1'b1));
    send_item(idle_item(clock_us + 24'hFF_FFFF, 1'b1));
    send_item(idle_item(clock_us + 24'hFF_FFFF + 1, 1'b1));
    clock_us = clock_us + 24'hFF_FFFF + 1;
    drain();
  endtask

  // Random traffic under one register setting; the sender pauses for a full
  // drain halfway through.
  task automatic test_random_phase(logic [kpb_pkg::INTERVAL_W-1:0] poll,
                                   logic [kpb_pkg::INTERVAL_W-1:0] probe,
                                   logic [kpb_pkg::INTERVAL_W-1:0] rel,
                                   logic [kpb_pkg::ADDR_W-1:0] dev,
                                   logic [kpb_pkg::ADDR_W-1:0] host, int odds, int count);
    drain();
    write_reg(kpb_pkg::REG_POLL_INTERVAL, poll);
    write_reg(kpb_pkg::REG_PROBE_INTERVAL, probe);
    write_reg(kpb_pkg::REG_RELEASE_TIMEOUT, rel);
    write_reg(kpb_pkg::REG_DEVICE_ADDRESS, {16'd0, dev});
    write_reg(kpb_pkg::REG_HOST_ADDRESS, {16'd0, host});
    idle_odds  = odds;
    stride_max = rel / 3 + 2;
    repeat (count / 2) send_item(random_item());
    drain();
    repeat (count - count / 2) send_item(random_item());
  endtask

  initial begin
    rst        = 1'b1;
    item_valid = 1'b0;
    item       = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    reset_model();
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    test_answers();
    test_time_wrap();
    test_register_extremes();
    test_random_phase(24'd37, 24'd150, 24'd400, 8'($urandom), 8'($urandom), 4, 480);
    test_random_phase(24'd1, 24'd1, 24'd1, kpb_pkg::DEVICE_ADDRESS_RST,
                      kpb_pkg::HOST_ADDRESS_RST, 8, 450);
    test_random_phase(24'($urandom_range(1, 2000)), 24'($urandom_range(1, 5000)),
                      24'($urandom_range(1, 8000)), 8'h00, 8'hFF, 3, 470);
    // closing stretch at reset intervals, random addresses, with no gaps or stalls
    test_random_phase(kpb_pkg::POLL_INTERVAL_RST, kpb_pkg::PROBE_INTERVAL_RST,
                      kpb_pkg::RELEASE_TIMEOUT_RST, 8'($urandom), 8'($urandom), 0, 500);

    drain();
    if (errors == 0)
      $display("keyboard_poll_bridge_test passed");
    else
      $display("keyboard_poll_bridge_test failed");
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/kpb_pkg.sv
rtl/kpb_cfg_regs.sv
rtl/kpb_step.sv
rtl/keyboard_poll_bridge.sv
rtl/kpb_checker.sv
test/keyboard_poll_bridge_test.sv
